/* rtl/assert_macros.svh */
// Assertion macros shared by the line folder RTL; they compile to nothing under SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The condition holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/lffb_pkg.sv */
// Shared types and constants of the line folder.
package lffb_pkg;

   // Field widths.
   localparam int CHAR_W = 8;
   localparam int FW_W   = 6;

   // Character codes.
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;

   // Action codes.
   localparam logic ACTION_CHAR = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   // Fold width after reset.
   localparam logic [FW_W-1:0] FOLD_WIDTH_RESET = 6'd5;

   // Command queue and output queue depths.
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = 2;
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_AW    = 2;

   // One result transaction.
   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              last_of_run;
   } out_item_type;

endpackage

/* rtl/lffb_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module lffb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lffb_cmd_fifo.sv */
// Short command queue between the front end and the emitting back end.
module lffb_cmd_fifo #(
   parameter int WIDTH = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0]              entry_ff [lffb_pkg::CMDQ_DEPTH];
   logic [lffb_pkg::CMDQ_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [lffb_pkg::CMDQ_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [lffb_pkg::CMDQ_AW:0]    count_ff, count_in;
   logic                          do_push, do_pop;

   assign full     = (count_ff == (lffb_pkg::CMDQ_AW+1)'(lffb_pkg::CMDQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + lffb_pkg::CMDQ_AW'(do_push);
      rd_ptr_in = rd_ptr_ff + lffb_pkg::CMDQ_AW'(do_pop);
      count_in  = count_ff + (lffb_pkg::CMDQ_AW+1)'(do_push)
                           - (lffb_pkg::CMDQ_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/lffb_front.sv */
// Front end: takes characters into the line buffer and decides folds and flushes.
`include "assert_macros.svh"
module lffb_front #(
   parameter int MAX_WIDTH = 32,
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int CW = $clog2(MAX_WIDTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [lffb_pkg::FW_W-1:0]     csr_wdata,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_action,
   input  logic [lffb_pkg::CHAR_W-1:0]   req_in_char,
   input  logic                          cmd_full,
   output logic                          cmd_push,
   output logic [CW-1:0]                 cmd_count,
   input  logic                          rd_issued,
   output logic                          ram_we,
   output logic [AW-1:0]                 ram_waddr,
   output logic [lffb_pkg::CHAR_W-1:0]   ram_wdata
);

   localparam logic [lffb_pkg::FW_W-1:0] MAX_FW  = lffb_pkg::FW_W'(MAX_WIDTH);
   localparam logic [CW-1:0]             MAX_CNT = CW'(MAX_WIDTH);

   logic [lffb_pkg::FW_W-1:0] fold_width_ff;
   logic [AW-1:0]             head_ff, head_in;
   logic [CW-1:0]             fill_ff, fill_in;
   logic [CW-1:0]             pending_ff, pending_in;
   logic [AW-1:0]             blank_pos_ff, blank_pos_in;
   logic                      blank_seen_ff, blank_seen_in;

   logic                      accept;
   logic [CW:0]               sum_fp;
   logic [AW:0]               tail_sum;
   logic [AW:0]               head_sum;
   logic [CW-1:0]             eff_width;
   logic                      is_blank;
   logic [CW-1:0]             fill_one;
   logic [AW-1:0]             pos_one;
   logic                      seen_one;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         fold_width_ff <= lffb_pkg::FOLD_WIDTH_RESET;
      end else if (csr_we) begin
         fold_width_ff <= csr_wdata;
      end
   end

   // Width clamped to the usable range.
   always_comb begin
      priority if (fold_width_ff == '0) begin
         eff_width = CW'(1);
      end else if (fold_width_ff > MAX_FW) begin
         eff_width = MAX_CNT;
      end else begin
         eff_width = fold_width_ff[CW-1:0];
      end
   end

   // Stall while the command queue is full or the next free slot still holds a character the back end has not read.
   assign sum_fp   = {1'b0, fill_ff} + {1'b0, pending_ff};
   assign req_full = cmd_full
                   | ((pending_ff != '0) && (sum_fp >= (CW+1)'(MAX_WIDTH)));
   assign accept   = req_push & ~req_full;

   // Write slot just past the buffered characters, modulo the buffer depth.
   assign tail_sum  = {1'b0, head_ff} + (AW+1)'(fill_ff);
   assign ram_waddr = (tail_sum >= (AW+1)'(MAX_WIDTH))
                    ? AW'(tail_sum - (AW+1)'(MAX_WIDTH)) : tail_sum[AW-1:0];
   assign ram_wdata = req_in_char;
   assign is_blank  = (req_in_char == lffb_pkg::CHAR_SPACE)
                    | (req_in_char == lffb_pkg::CHAR_TAB);

   // New buffer start after the emitted characters have been handed over.
   assign head_sum = {1'b0, head_ff} + (AW+1)'(cmd_count);

   // Classify the transaction and update the buffer bookkeeping.
   always_comb begin
      cmd_push      = 1'b0;
      cmd_count     = fill_ff;
      ram_we        = 1'b0;
      fill_in       = fill_ff;
      blank_pos_in  = blank_pos_ff;
      blank_seen_in = blank_seen_ff;
      fill_one      = fill_ff;
      pos_one       = blank_pos_ff;
      seen_one      = blank_seen_ff;
      if (accept) begin
         priority if (req_action == lffb_pkg::ACTION_END) begin
            if (fill_ff != '0) begin
               cmd_push = 1'b1;
            end
         end else if (req_in_char == lffb_pkg::CHAR_NEWLINE) begin
            cmd_push = 1'b1;
         end else begin
            if (fill_ff < MAX_CNT) begin
               ram_we   = 1'b1;
               fill_one = fill_ff + CW'(1);
               if (is_blank) begin
                  seen_one = 1'b1;
                  pos_one  = AW'(fill_ff);
               end
            end
            if (fill_one >= eff_width) begin
               cmd_push  = 1'b1;
               cmd_count = seen_one ? (CW'(pos_one) + CW'(1)) : fill_one;
            end
            fill_in       = fill_one;
            blank_pos_in  = pos_one;
            blank_seen_in = seen_one;
         end
         // Everything up to the last blank leaves; the rest holds no blank.
         if (cmd_push) begin
            fill_in       = fill_one - cmd_count;
            blank_pos_in  = '0;
            blank_seen_in = 1'b0;
         end
      end
   end

   always_comb begin
      head_in = head_ff;
      if (cmd_push) begin
         head_in = (head_sum >= (AW+1)'(MAX_WIDTH))
                 ? AW'(head_sum - (AW+1)'(MAX_WIDTH)) : head_sum[AW-1:0];
      end
      pending_in = pending_ff + (cmd_push ? cmd_count : '0) - CW'(rd_issued);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         fill_ff       <= '0;
         pending_ff    <= '0;
         blank_pos_ff  <= '0;
         blank_seen_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         pending_ff    <= pending_in;
         blank_pos_ff  <= blank_pos_in;
         blank_seen_ff <= blank_seen_in;
      end
   end

   `ASSERT_HOLDS(a_no_overrun, clock, reset, sum_fp <= (CW+1)'(MAX_WIDTH), "buffer overrun")
   `ASSERT_IMPLIES(a_blank_inside, clock, reset, blank_seen_ff, CW'(blank_pos_ff) < fill_ff, "blank outside buffer")

endmodule

/* rtl/lffb_back.sv */
// Back end: reads folded runs out of the line buffer and queues the result characters.
`include "assert_macros.svh"
module lffb_back #(
   parameter int MAX_WIDTH = 32,
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int CW = $clog2(MAX_WIDTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_empty,
   input  logic [CW-1:0]                 cmd_count,
   output logic                          cmd_pop,
   output logic                          rd_issued,
   output logic                          ram_re,
   output logic [AW-1:0]                 ram_raddr,
   input  logic [lffb_pkg::CHAR_W-1:0]   ram_rdata,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic [lffb_pkg::CHAR_W-1:0]   rsp_out_char,
   output logic                          rsp_last_of_run
);

   localparam logic BK_IDLE = 1'b0;
   localparam logic BK_RUN  = 1'b1;

   logic                            state_ff, state_in;
   logic [CW-1:0]                   rem_ff, rem_in;
   logic [AW-1:0]                   rd_ptr_ff, rd_ptr_in;
   logic                            s1_valid_ff;
   logic                            s1_nl_ff;
   lffb_pkg::out_item_type          outq_ff [lffb_pkg::OUTQ_DEPTH];
   logic [lffb_pkg::OUTQ_AW-1:0]    oq_wr_ff, oq_rd_ff;
   logic [lffb_pkg::OUTQ_AW:0]      oq_cnt_ff, oq_cnt_in;
   lffb_pkg::out_item_type          oq_item;
   logic                            credit, issue, issue_rd, issue_nl, oq_pop;

   // Issue only when the output queue has room for everything in flight.
   assign credit   = (oq_cnt_ff + (lffb_pkg::OUTQ_AW+1)'(s1_valid_ff))
                   < (lffb_pkg::OUTQ_AW+1)'(lffb_pkg::OUTQ_DEPTH);
   assign issue    = (state_ff == BK_RUN) & credit;
   assign issue_rd = issue & (rem_ff != '0);
   assign issue_nl = issue & (rem_ff == '0);
   assign cmd_pop  = (state_ff == BK_IDLE) & ~cmd_empty;

   assign ram_re    = issue_rd;
   assign ram_raddr = rd_ptr_ff;
   assign rd_issued = issue_rd;

   // Run sequencer: buffered characters first, then the newline.
   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      rd_ptr_in = rd_ptr_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_pop) begin
               state_in = BK_RUN;
               rem_in   = cmd_count;
            end
         end
         BK_RUN: begin
            if (issue_rd) begin
               rem_in    = rem_ff - CW'(1);
               rd_ptr_in = (rd_ptr_ff == AW'(MAX_WIDTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
            end
            if (issue_nl) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         rem_ff      <= '0;
         rd_ptr_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rem_ff      <= rem_in;
         rd_ptr_ff   <= rd_ptr_in;
         s1_valid_ff <= issue;
      end
   end

   // Read stage marker; the RAM data arrives alongside it.
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_nl_ff <= issue_nl;
      end
   end

   // Output queue that decouples the emitter from the receiver.
   assign oq_item.out_char    = s1_nl_ff ? lffb_pkg::CHAR_NEWLINE : ram_rdata;
   assign oq_item.last_of_run = s1_nl_ff;
   assign rsp_empty           = (oq_cnt_ff == '0);
   assign oq_pop              = rsp_pop & ~rsp_empty;
   assign oq_cnt_in           = oq_cnt_ff + (lffb_pkg::OUTQ_AW+1)'(s1_valid_ff)
                              - (lffb_pkg::OUTQ_AW+1)'(oq_pop);
   assign rsp_out_char        = outq_ff[oq_rd_ff].out_char;
   assign rsp_last_of_run     = outq_ff[oq_rd_ff].last_of_run;

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         oq_wr_ff  <= oq_wr_ff + lffb_pkg::OUTQ_AW'(s1_valid_ff);
         oq_rd_ff  <= oq_rd_ff + lffb_pkg::OUTQ_AW'(oq_pop);
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         outq_ff[oq_wr_ff] <= oq_item;
      end
   end

   `ASSERT_HOLDS(a_outq_bound, clock, reset, oq_cnt_ff <= (lffb_pkg::OUTQ_AW+1)'(lffb_pkg::OUTQ_DEPTH), "output queue overflow")
   `ASSERT_NEXT(a_nl_ends_run, clock, reset, issue_nl, state_ff == BK_IDLE, "run did not end after newline")

endmodule

/* rtl/line_fold_at_last_blank_core.sv */
// Top level of the word-wrap line folder.
// Usage: characters arrive as transactions on the req_ queue port (push/full) with
// req_action 0; req_action 1 ends the input and flushes the buffer. Results leave on
// the rsp_ queue port (empty/pop), one character per transaction; rsp_last_of_run
// marks the newline that closes each run caused by one input transaction.
// csr_we/csr_wdata set the fold width; write it only while the block is idle.
// A character that does not fill the line produces no result.
// A fold, newline or end transaction is queued as a command; its first character
// passes the command queue, the run state, the RAM read stage and the output queue
// to reach the result ports, and the run then streams one character per cycle while
// the receiver pops. Characters that stay buffered are accepted one per cycle while
// full is low; the sustained rate is set by the runs, as the emitter reads the single
// read port of the line buffer RAM once per buffered character.
// full rises when the command queue is full, or when the next buffer slot still
// holds a character that has been folded out but not yet read.
// Reset clears all control state and sets the fold width to 5; the buffer RAM is
// not cleared, as only written entries are ever read.
// When the receiver stalls, the output queue fills, the emitter waits, commands
// back up and finally full is raised; no transaction is lost.
module line_fold_at_last_blank_core #(
   parameter int MAX_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [lffb_pkg::FW_W-1:0]     csr_wdata,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_action,
   input  logic [lffb_pkg::CHAR_W-1:0]   req_in_char,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic [lffb_pkg::CHAR_W-1:0]   rsp_out_char,
   output logic                          rsp_last_of_run
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW = $clog2(MAX_WIDTH + 1);

   logic                          cmd_full, cmd_push, cmd_pop, cmd_empty;
   logic [CW-1:0]                 push_count, pop_count;
   logic                          rd_issued;
   logic                          ram_we, ram_re;
   logic [AW-1:0]                 ram_waddr, ram_raddr;
   logic [lffb_pkg::CHAR_W-1:0]   ram_wdata, ram_rdata;

   // Classification and buffer bookkeeping.
   lffb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_action  (req_action),
      .req_in_char (req_in_char),
      .cmd_full    (cmd_full),
      .cmd_push    (cmd_push),
      .cmd_count   (push_count),
      .rd_issued   (rd_issued),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata)
   );

   // Commands waiting for the emitter.
   lffb_cmd_fifo #(.WIDTH(CW)) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_count),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (pop_count),
      .empty     (cmd_empty)
   );

   // Line buffer, used as a circular store.
   lffb_ram #(.WIDTH(lffb_pkg::CHAR_W), .DEPTH(MAX_WIDTH)) u_line_buffer (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Emitter and output queue.
   lffb_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_empty       (cmd_empty),
      .cmd_count       (pop_count),
      .cmd_pop         (cmd_pop),
      .rd_issued       (rd_issued),
      .ram_re          (ram_re),
      .ram_raddr       (ram_raddr),
      .ram_rdata       (ram_rdata),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

/* tb/fold_check_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard of the line folder: predicts the output characters and checks what arrives.
package fold_check_pkg;
   import lffb_pkg::*;

   localparam int LINE_MAX    = 32;
   localparam int SHOW_ERRORS = 10;

   class fold_scoreboard;
      // Own copy of the folding state and of the fold width register.
      logic [CHAR_W-1:0] line_q [LINE_MAX];
      int unsigned       used       = 0;
      int unsigned       last_blank = 0;
      bit                has_blank  = 1'b0;
      logic [FW_W-1:0]   width_reg  = FOLD_WIDTH_RESET;

      out_item_type      expected_q [$];
      int unsigned       inputs  = 0;
      int unsigned       checked = 0;
      int unsigned       errors  = 0;

      function void set_width(logic [FW_W-1:0] v);
         width_reg = v;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function bit is_blank(logic [CHAR_W-1:0] c);
         return c == CHAR_SPACE || c == CHAR_TAB;
      endfunction

      function void emit(logic [CHAR_W-1:0] c);
         out_item_type item;
         item.out_char    = c;
         item.last_of_run = 1'b0;
         expected_q.push_back(item);
      endfunction

      // Everything buffered goes out, closed by a newline.
      function void flush_line();
         for (int i = 0; i < used; i++) emit(line_q[i]);
         emit(CHAR_NEWLINE);
         used       = 0;
         has_blank  = 1'b0;
         last_blank = 0;
      endfunction

      // Only the first ten problems are shown in full; the rest are counted.
      function void note_problem(string what);
         errors++;
         if (errors <= SHOW_ERRORS) $display("ERROR at %0t: %s", $realtime, what);
      endfunction

      // Works out the characters that one accepted input transaction causes.
      function void note_input(logic act, logic [CHAR_W-1:0] c);
         int unsigned start;
         int unsigned w;
         int unsigned cut;
         start = expected_q.size();
         w = (width_reg == 0) ? 1 : (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
         inputs++;
         if (act == ACTION_END) begin
            if (used > 0) flush_line();
         end else if (c == CHAR_NEWLINE) begin
            flush_line();
         end else begin
            if (used < LINE_MAX) begin
               line_q[used] = c;
               if (is_blank(c)) begin
                  last_blank = used;
                  has_blank  = 1'b1;
               end
               used++;
            end
            if (used >= w) begin
               if (!has_blank || last_blank >= used) begin
                  flush_line();
               end else begin
                  // Emit up to and including the last blank, keep the tail and rescan it.
                  cut = last_blank + 1;
                  for (int i = 0; i < cut; i++) emit(line_q[i]);
                  emit(CHAR_NEWLINE);
                  for (int i = 0; i < used - cut; i++) line_q[i] = line_q[i + cut];
                  used       = used - cut;
                  has_blank  = 1'b0;
                  last_blank = 0;
                  for (int i = 0; i < used; i++) begin
                     if (is_blank(line_q[i])) begin
                        last_blank = i;
                        has_blank  = 1'b1;
                     end
                  end
               end
            end
         end
         if (expected_q.size() > start) expected_q[expected_q.size() - 1].last_of_run = 1'b1;
      endfunction

      // Compares one accepted output transaction with the oldest expectation.
      function void check_result(logic [CHAR_W-1:0] ch, logic last);
         out_item_type want;
         checked++;
         if (expected_q.size() == 0) begin
            note_problem($sformatf("unexpected output char %02h last %0b", ch, last));
            return;
         end
         want = expected_q.pop_front();
         if (ch !== want.out_char)
            note_problem($sformatf("output %0d: out_char expected %02h, got %02h",
                                   checked, want.out_char, ch));
         if (last !== want.last_of_run)
            note_problem($sformatf("output %0d: last_of_run expected %0b, got %0b",
                                   checked, want.last_of_run, last));
      endfunction

      function void check_leftover();
         if (expected_q.size() != 0)
            note_problem($sformatf("%0d expected output characters never arrived",
                                   expected_q.size()));
      endfunction
   endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Top of the line folder testbench: clock, reset, stimulus, handshakes and the verdict.
module tb_top;
   import lffb_pkg::*;
   import fold_check_pkg::*;

   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 50;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_we      = 1'b0;
   logic [FW_W-1:0]   csr_wdata   = '0;
   logic              req_push    = 1'b0;
   logic              req_action  = ACTION_CHAR;
   logic [CHAR_W-1:0] req_in_char = '0;
   logic              rsp_pop     = 1'b0;
   logic              req_full;
   logic              rsp_empty;
   logic [CHAR_W-1:0] rsp_out_char;
   logic              rsp_last_of_run;

   // While set, neither side idles.
   bit                steady = 1'b0;
   int unsigned       end_actions  = 0;
   int unsigned       width_writes = 0;
   fold_scoreboard    sb;

   line_fold_at_last_blank_core #(
      .MAX_WIDTH(LINE_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_push(req_push),
      .req_full(req_full),
      .req_action(req_action),
      .req_in_char(req_in_char),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_out_char(rsp_out_char),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The receiver stalls at random unless a steady stretch is running.
   always @(posedge clock) begin
      rsp_pop <= steady || ($urandom_range(99) >= 31);
   end

   // Outputs are sampled at the falling edge after they change; the transaction completes at the next edge.
   always @(negedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_result(rsp_out_char, rsp_last_of_run);
   end

   // Offers one input transaction, with random idle cycles first, and waits until it is taken.
   task automatic send_item(input logic act, input logic [CHAR_W-1:0] ch);
      while (!steady && $urandom_range(99) < 31) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_action  <= act;
      req_in_char <= ch;
      @(negedge clock);
      while (req_full) @(negedge clock);
      sb.note_input(act, ch);
      if (act == ACTION_END) end_actions++;
      @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(ACTION_CHAR, s[i]);
   endtask

   // Holds off the sender until every expected character has come and the block is quiet.
   task automatic drain_and_settle();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [FW_W-1:0] v);
      drain_and_settle();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      sb.set_width(v);
      width_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly lower-case words split by blanks, with some newlines and arbitrary bytes.
   function automatic logic [CHAR_W-1:0] pick_char();
      int r;
      r = $urandom_range(99);
      if (r < 18) return CHAR_SPACE;
      else if (r < 22) return CHAR_TAB;
      else if (r < 26) return CHAR_NEWLINE;
      else if (r < 36) return CHAR_W'($urandom_range(255));
      else return CHAR_W'($urandom_range(122, 97));
   endfunction

   initial begin
      logic [FW_W-1:0] widths [RANDOM_PHASES];
      widths = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd12, 6'd3, 6'd5, 6'd5};
      widths[6] = FW_W'($urandom_range(63));
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset width of five columns.
      send_item(ACTION_END, 8'hFF);
      send_item(ACTION_CHAR, CHAR_NEWLINE);
      send_text("ab cd");
      send_item(ACTION_CHAR, 8'h00);
      send_item(ACTION_CHAR, 8'hFF);
      send_text("e");
      send_text("xyzw\t");
      send_text("mn");
      send_item(ACTION_END, CHAR_NEWLINE);

      // The width is lowered while a long line is still buffered.
      write_width(6'd20);
      send_text("ab cdefgh");
      write_width(6'd3);
      send_text("ij");

      // Random part: one phase per fold width, the buffer carried across each change.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_width(widths[p]);
         steady = (p == 3);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(99) < 3) send_item(ACTION_END, CHAR_W'($urandom_range(255)));
            else send_item(ACTION_CHAR, pick_char());
         end
         steady = 1'b0;
      end

      drain_and_settle();
      sb.check_leftover();
      $display("Sent %0d input transactions, %0d of them end actions, over %0d width settings.",
               sb.inputs, end_actions, width_writes);
      $display("Checked %0d output characters; %0d problems found.", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #400000;
      $display("Timed out with %0d output characters still expected.", sb.pending());
      $display("simulation failed");
      $finish;
   end

endmodule
